/* hdl/life_grid_engine_assert.svh */
`ifndef LIFE_GRID_ENGINE_ASSERT_SVH
`define LIFE_GRID_ENGINE_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define LGE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define LGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lge_pkg.sv */
package lge_pkg;

  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 64;

  localparam int CMD_W     = 2;
  localparam int COORD_W   = 6;
  localparam int DIM_CFG_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NB_W      = 4;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = 7'd64;

  localparam logic [NB_W-1:0] SURVIVE_MIN = 4'd2;
  localparam logic [NB_W-1:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_ALIVE = 2'd0,
    CMD_SET_DEAD  = 2'd1,
    CMD_READ      = 2'd2,
    CMD_ADVANCE   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_t;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_C_MID   = 7'b0000100,
    S_C_DN    = 7'b0001000,
    S_C_CALC  = 7'b0010000,
    S_A_FIRST = 7'b0100000,
    S_A_ROW   = 7'b1000000
  } state_t;

endpackage

/* hdl/life_grid_engine.sv */
// In-range set, clear and read commands pass through S_C_MID, S_C_DN and S_C_CALC before the registered strobe.
// Advance passes S_A_FIRST, then S_A_ROW per row in use (0 counts as 1), one grid row per cycle.
// A bad coordinate is reported in the cycle after its transfer and never raises busy.
// Busy is low again in the strobe cycle, so the next transfer can follow at once.
// After reset the row memory is cleared one row per cycle through all GRID_ROWS rows, busy high.
// Results are strobed for one cycle and the receiver cannot stall.
`include "life_grid_engine_assert.svh"

module life_grid_engine
  import lge_pkg::*;
#(
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int GRID_ROWS = GRID_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [COORD_W-1:0]   in_col,
  input  logic [COORD_W-1:0]   in_row,
  output logic                 out_valid,
  output logic                 out_alive,
  output logic [NB_W-1:0]      out_neighbours,
  output logic                 out_bad_coord,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_CFG_W-1:0] cfg_data
);

  localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CX_A  = $clog2(GRID_COLS) + 2;
  localparam int CX_W  = (CX_A > DIM_CFG_W + 1) ? CX_A : DIM_CFG_W + 1;
  localparam int RX_A  = $clog2(GRID_ROWS) + 2;
  localparam int RX_W  = (RX_A > DIM_CFG_W + 1) ? RX_A : DIM_CFG_W + 1;
  localparam int PX_W  = $clog2(GRID_COLS + 2);

  function automatic logic [NB_W-1:0] count8(input logic [7:0] b);
    logic [NB_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + NB_W'(b[i]);
    end
    return s;
  endfunction

  function automatic logic next_alive(input logic a, input logic [NB_W-1:0] n);
    logic res;
    if (a) begin
      res = (n == SURVIVE_MIN) || (n == BIRTH_COUNT);
    end else begin
      res = (n == BIRTH_COUNT);
    end
    return res;
  endfunction

  state_t state_r, state_nxt;

  logic [DIM_CFG_W-1:0] cols_r, rows_r;
  logic [CX_W-1:0]      ncols;
  logic [RX_W-1:0]      nrows;
  logic [GRID_COLS-1:0] colmask;

  cmd_t                 cmd_r;
  logic [COL_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic                 up_ok_r;
  logic [GRID_COLS-1:0] up_r, mid_r, rdata_r;

  logic                 out_valid_r, out_alive_r, out_bad_coord_r;
  logic [NB_W-1:0]      out_neighbours_r;

  logic [GRID_COLS-1:0] cell_mem [GRID_ROWS];

  logic                 rd_en, wr_en;
  logic [ROW_W-1:0]     rd_addr, wr_addr;
  logic [GRID_COLS-1:0] wr_data;

  logic                 accept, bad_in, dn_ok, last_row, dn2_ok, out_fire;
  logic [GRID_COLS-1:0] u_m, m_m, d_m, gen_row, mid_new;
  logic [GRID_COLS+1:0] up_p, mid_p, dn_p;
  logic [PX_W-1:0]      cidx;
  logic [NB_W-1:0]      cell_cnt;
  logic [ROW_W-1:0]     in_row_t;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign out_valid      = out_valid_r;
  assign out_alive      = out_alive_r;
  assign out_neighbours = out_neighbours_r;
  assign out_bad_coord  = out_bad_coord_r;

  always_comb begin
    logic [CX_W-1:0] cext;
    logic [RX_W-1:0] rext;
    cext = CX_W'(cols_r);
    rext = RX_W'(rows_r);
    if (cols_r == '0) begin
      ncols = CX_W'(1);
    end else if (cext > CX_W'(GRID_COLS)) begin
      ncols = CX_W'(GRID_COLS);
    end else begin
      ncols = cext;
    end
    if (rows_r == '0) begin
      nrows = RX_W'(1);
    end else if (rext > RX_W'(GRID_ROWS)) begin
      nrows = RX_W'(GRID_ROWS);
    end else begin
      nrows = rext;
    end
  end

  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      colmask[c] = (CX_W'(c) < ncols);
    end
  end

  assign bad_in   = (CX_W'(in_col) >= ncols) || (RX_W'(in_row) >= nrows);
  assign in_row_t = ROW_W'(in_row);
  assign dn_ok    = (RX_W'(row_r) + RX_W'(1)) < nrows;
  assign dn2_ok   = (RX_W'(row_r) + RX_W'(2)) < nrows;
  assign last_row = (RX_W'(row_r) + RX_W'(1)) == nrows;

  assign out_fire = ((state_r == S_IDLE) && accept &&
                     (cmd_t'(in_command) != CMD_ADVANCE) && bad_in) ||
                    (state_r == S_C_CALC) ||
                    ((state_r == S_A_ROW) && last_row);

  assign u_m   = up_r & colmask;
  assign m_m   = mid_r & colmask;
  assign d_m   = dn_ok ? (rdata_r & colmask) : '0;
  assign up_p  = {1'b0, u_m, 1'b0};
  assign mid_p = {1'b0, m_m, 1'b0};
  assign dn_p  = {1'b0, d_m, 1'b0};

  always_comb begin
    logic [NB_W-1:0] n;
    for (int c = 0; c < GRID_COLS; c++) begin
      n = count8({up_p[c], up_p[c+1], up_p[c+2], mid_p[c], mid_p[c+2],
                  dn_p[c], dn_p[c+1], dn_p[c+2]});
      gen_row[c] = colmask[c] ? next_alive(mid_r[c], n) : mid_r[c];
    end
  end

  assign cidx     = PX_W'(col_r);
  assign cell_cnt = count8({up_p[cidx], up_p[cidx + PX_W'(1)], up_p[cidx + PX_W'(2)],
                            mid_p[cidx], mid_p[cidx + PX_W'(2)],
                            dn_p[cidx], dn_p[cidx + PX_W'(1)], dn_p[cidx + PX_W'(2)]});

  always_comb begin
    mid_new = mid_r;
    unique case (cmd_r)
      CMD_SET_ALIVE: mid_new[col_r] = 1'b1;
      CMD_SET_DEAD:  mid_new[col_r] = 1'b0;
      CMD_READ:      mid_new = mid_r;
      CMD_ADVANCE:   mid_new = mid_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = row_r;
    wr_en     = 1'b0;
    wr_addr   = row_r;
    wr_data   = '0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (row_r == ROW_W'(GRID_ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd_t'(in_command) == CMD_ADVANCE) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_A_FIRST;
          end else if (!bad_in) begin
            rd_en     = (in_row != '0);
            rd_addr   = in_row_t - ROW_W'(1);
            state_nxt = S_C_MID;
          end
        end
      end
      S_C_MID: begin
        rd_en     = 1'b1;
        state_nxt = S_C_DN;
      end
      S_C_DN: begin
        rd_en     = dn_ok;
        rd_addr   = row_r + ROW_W'(1);
        state_nxt = S_C_CALC;
      end
      S_C_CALC: begin
        wr_en     = 1'b1;
        wr_data   = mid_new;
        state_nxt = S_IDLE;
      end
      S_A_FIRST: begin
        rd_en     = dn_ok;
        rd_addr   = row_r + ROW_W'(1);
        state_nxt = S_A_ROW;
      end
      S_A_ROW: begin
        wr_en   = 1'b1;
        wr_data = gen_row;
        rd_en   = dn2_ok;
        rd_addr = row_r + ROW_W'(2);
        if (last_row) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= cell_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= DIM_RESET;
      rows_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLS: cols_r <= cfg_data;
        CFG_ROWS: rows_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      cmd_r       <= CMD_READ;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_fire;
      unique case (state_r)
        S_CLEAR: begin
          row_r <= row_r + ROW_W'(1);
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= cmd_t'(in_command);
            col_r   <= COL_W'(in_col);
            row_r   <= (cmd_t'(in_command) == CMD_ADVANCE) ? '0 : in_row_t;
            up_ok_r <= (in_row != '0);
            if (cmd_t'(in_command) == CMD_ADVANCE) begin
              up_r <= '0;
            end else if (bad_in) begin
              out_alive_r      <= 1'b0;
              out_neighbours_r <= '0;
              out_bad_coord_r  <= 1'b1;
            end
          end
        end
        S_C_MID: begin
          up_r <= up_ok_r ? rdata_r : '0;
        end
        S_C_DN: begin
          mid_r <= rdata_r;
        end
        S_C_CALC: begin
          out_alive_r      <= mid_new[col_r];
          out_neighbours_r <= cell_cnt;
          out_bad_coord_r  <= 1'b0;
        end
        S_A_FIRST: begin
          mid_r <= rdata_r;
        end
        S_A_ROW: begin
          up_r  <= mid_r;
          mid_r <= rdata_r;
          if (last_row) begin
            out_alive_r      <= 1'b0;
            out_neighbours_r <= '0;
            out_bad_coord_r  <= 1'b0;
          end else begin
            row_r <= row_r + ROW_W'(1);
          end
        end
        default: row_r <= row_r;
      endcase
    end
  end

  `LGE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "transfer was dropped")
  `LGE_ASSERT_NOW(a_bad_clean, out_valid && out_bad_coord, !out_alive && out_neighbours == '0, "bad coordinate result not clean")
  `LGE_ASSERT_NOW(a_count_range, out_valid, out_neighbours <= NB_W'(8), "neighbour count above eight")
  `LGE_ASSERT_NEXT(a_clear_quiet, state_r == S_CLEAR, !out_valid, "result during clearing pass")

endmodule

/* bench/tb_life_grid_engine.sv */
`timescale 1ns / 1ps

module tb_life_grid_engine;
  import lge_pkg::*;

  localparam int CELLS      = GRID_COLS_DEF * GRID_ROWS_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int PHASES     = 10;
  localparam int PHASE_CMDS = 52;

  typedef struct packed {
    logic            alive;
    logic [NB_W-1:0] neighbours;
    logic            bad_coord;
  } cell_result_t;

  typedef struct {
    bit                   is_reg;
    cfg_idx_t             reg_idx;
    logic [DIM_CFG_W-1:0] reg_val;
    cmd_t                 cmd;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    bit                   typed;
    cell_result_t         want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_command;
  logic [COORD_W-1:0]   in_col;
  logic [COORD_W-1:0]   in_row;
  logic                 out_valid;
  logic                 out_alive;
  logic [NB_W-1:0]      out_neighbours;
  logic                 out_bad_coord;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_CFG_W-1:0] cfg_data;

  bit                   board [0:CELLS-1];
  logic [DIM_CFG_W-1:0] cols_cfg = DIM_RESET;
  logic [DIM_CFG_W-1:0] rows_cfg = DIM_RESET;
  cell_result_t         pending_cells[$];
  bit                   typed_now;
  cell_result_t         typed_res;
  step_t                plan[$];

  int errors     = 0;
  int cmd_count  = 0;
  int adv_count  = 0;
  int bad_count  = 0;
  int reg_count  = 0;
  int idle_count = 0;

  life_grid_engine uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_alive      (out_alive),
    .out_neighbours (out_neighbours),
    .out_bad_coord  (out_bad_coord),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clamp_dim(logic [DIM_CFG_W-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic int live_around(int c, int r, int nc, int nr);
    int n = 0;
    int rr;
    int cc;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc)
          n += board[rr * GRID_COLS_DEF + cc];
      end
    end
    return n;
  endfunction

  function automatic cell_result_t apply_command(cmd_t cmd, int col, int row);
    cell_result_t res;
    bit           nxt [0:CELLS-1];
    int           nc;
    int           nr;
    int           n;
    int           idx;
    res = '0;
    nc = clamp_dim(cols_cfg, GRID_COLS_DEF);
    nr = clamp_dim(rows_cfg, GRID_ROWS_DEF);
    if (cmd == CMD_ADVANCE) begin
      nxt = board;
      for (int r = 0; r < nr; r++) begin
        for (int c = 0; c < nc; c++) begin
          idx = r * GRID_COLS_DEF + c;
          n = live_around(c, r, nc, nr);
          if (board[idx])
            nxt[idx] = (n == SURVIVE_MIN || n == BIRTH_COUNT);
          else
            nxt[idx] = (n == BIRTH_COUNT);
        end
      end
      board = nxt;
      return res;
    end
    if (col >= nc || row >= nr) begin
      res.bad_coord = 1'b1;
      return res;
    end
    idx = row * GRID_COLS_DEF + col;
    if (cmd == CMD_SET_ALIVE)
      board[idx] = 1'b1;
    else if (cmd == CMD_SET_DEAD)
      board[idx] = 1'b0;
    res.alive      = board[idx];
    res.neighbours = NB_W'(live_around(col, row, nc, nr));
    return res;
  endfunction

  function automatic step_t op(cmd_t cmd, int col, int row);
    step_t s;
    s.is_reg  = 1'b0;
    s.reg_idx = CFG_COLS;
    s.reg_val = '0;
    s.cmd     = cmd;
    s.col     = COORD_W'(col);
    s.row     = COORD_W'(row);
    s.typed   = 1'b0;
    s.want    = '0;
    return s;
  endfunction

  function automatic step_t op_is(cmd_t cmd, int col, int row, int alive, int nb, int bad);
    step_t s;
    s = op(cmd, col, row);
    s.typed = 1'b1;
    s.want  = '{alive: alive[0], neighbours: NB_W'(nb), bad_coord: bad[0]};
    return s;
  endfunction

  function automatic step_t reg_set(cfg_idx_t idx, int val);
    step_t s;
    s = op(CMD_READ, 0, 0);
    s.is_reg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = DIM_CFG_W'(val);
    return s;
  endfunction

  function automatic logic [DIM_CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 7'd127;
      2: return DIM_RESET;
      3: return 7'd1;
      4: return DIM_CFG_W'($urandom_range(65, 127));
      5: return DIM_CFG_W'($urandom_range(13, 63));
      default: return DIM_CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    if (errors <= 20)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic issue(cmd_t cmd, logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                       bit typed, cell_result_t want);
    start      <= 1'b1;
    in_command <= cmd;
    in_col     <= col;
    in_row     <= row;
    typed_now  <= typed;
    typed_res  <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_sender(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic settle();
    if (start) start <= 1'b0;
    @(posedge clk);
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [DIM_CFG_W-1:0] val);
    repeat ($urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    cell_result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_count++;
        if (cfg_idx_t'(cfg_index) == CFG_COLS)
          cols_cfg = cfg_data;
        else
          rows_cfg = cfg_data;
      end
      if (start && !busy) begin
        want = apply_command(cmd_t'(in_command), in_col, in_row);
        if (typed_now) want = typed_res;
        pending_cells.push_back(want);
        cmd_count++;
        if (cmd_t'(in_command) == CMD_ADVANCE) adv_count++;
        if (want.bad_coord) bad_count++;
      end
      if (out_valid) begin
        got = '{alive: out_alive, neighbours: out_neighbours, bad_coord: out_bad_coord};
        if (pending_cells.size() == 0) begin
          report("result with nothing pending, alive", got.alive, 0);
        end else begin
          want = pending_cells.pop_front();
          if (got.alive !== want.alive) report("alive", got.alive, want.alive);
          if (got.neighbours !== want.neighbours)
            report("neighbours", got.neighbours, want.neighbours);
          if (got.bad_coord !== want.bad_coord)
            report("bad_coord", got.bad_coord, want.bad_coord);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    logic [DIM_CFG_W-1:0] cv;
    logic [DIM_CFG_W-1:0] rv;
    int                   nc;
    int                   nr;
    int                   pick;
    cmd_t                 cmd;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;

    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_command <= '0;
    in_col     <= '0;
    in_row     <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_COLS;
    cfg_data   <= '0;
    typed_now  <= 1'b0;
    typed_res  <= '0;

    plan = '{
      op_is(CMD_READ, 0, 0, 0, 0, 0),
      op_is(CMD_READ, 63, 63, 0, 0, 0),
      op_is(CMD_SET_DEAD, 63, 63, 0, 0, 0),
      op_is(CMD_SET_ALIVE, 0, 0, 1, 0, 0),
      op_is(CMD_SET_ALIVE, 0, 0, 1, 0, 0),
      op(CMD_SET_ALIVE, 1, 0),
      op(CMD_SET_ALIVE, 2, 0),
      op_is(CMD_ADVANCE, 5, 9, 0, 0, 0),
      op(CMD_READ, 1, 1),
      op(CMD_SET_ALIVE, 63, 62),
      op(CMD_SET_ALIVE, 62, 63),
      op(CMD_SET_ALIVE, 63, 63),
      op_is(CMD_ADVANCE, 63, 63, 0, 0, 0),
      op(CMD_READ, 62, 62),
      reg_set(CFG_COLS, 0),
      reg_set(CFG_ROWS, 127),
      op_is(CMD_READ, 1, 0, 0, 0, 1),
      op(CMD_READ, 0, 63),
      op(CMD_SET_ALIVE, 0, 5),
      reg_set(CFG_COLS, 3),
      reg_set(CFG_ROWS, 2),
      op_is(CMD_ADVANCE, 0, 0, 0, 0, 0),
      op_is(CMD_READ, 0, 2, 0, 0, 1),
      op_is(CMD_SET_DEAD, 3, 0, 0, 0, 1),
      op_is(CMD_READ, 63, 63, 0, 0, 1),
      op(CMD_SET_ALIVE, 2, 1),
      reg_set(CFG_COLS, 64),
      reg_set(CFG_ROWS, 64),
      op(CMD_READ, 62, 62),
      op_is(CMD_ADVANCE, 0, 0, 0, 0, 0),
      op(CMD_READ, 1, 1)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        issue(plan[i].cmd, plan[i].col, plan[i].row, plan[i].typed, plan[i].want);
        idle_sender(1'b1);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      cv = pick_dim();
      rv = pick_dim();
      settle();
      write_reg(CFG_COLS, cv);
      write_reg(CFG_ROWS, rv);
      nc = clamp_dim(cv, GRID_COLS_DEF);
      nr = clamp_dim(rv, GRID_ROWS_DEF);
      for (int k = 0; k < PHASE_CMDS; k++) begin
        if (p < PHASES - 1 && $urandom_range(0, 49) == 0) settle();
        pick = $urandom_range(0, 99);
        if (pick < 35)      cmd = CMD_SET_ALIVE;
        else if (pick < 50) cmd = CMD_SET_DEAD;
        else if (pick < 78) cmd = CMD_READ;
        else                cmd = CMD_ADVANCE;
        if ($urandom_range(0, 99) < 85) begin
          col = COORD_W'($urandom_range(0, nc - 1));
          row = COORD_W'($urandom_range(0, nr - 1));
        end else begin
          col = COORD_W'($urandom_range(0, 63));
          row = COORD_W'($urandom_range(0, 63));
        end
        issue(cmd, col, row, 1'b0, '0);
        idle_sender(p < PHASES - 1);
      end
    end

    settle();
    repeat (GRID_ROWS_DEF + 8) @(posedge clk);

    $display("Run covered %0d commands, %0d of them generation steps and %0d off-grid,",
             cmd_count, adv_count, bad_count);
    $display("across %0d register writes of grid width and height.", reg_count);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
